### rtl/assert_macros.svh
// Assertion macros used by the stack machine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication within the same clock cycle.
`define AST_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication into the following clock cycle.
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/smx_pkg.sv
// Types and constants of the stack machine execution unit.
package smx_pkg;

    localparam int CMD_BITS       = 4;
    localparam int OPERAND_BITS   = 32;
    localparam int IP_BITS        = 32;
    localparam int STATUS_BITS    = 2;
    localparam int DEPTH_OUT_BITS = 9;
    localparam int PLEN_BITS      = 31;

    typedef logic [CMD_BITS-1:0]    t_cmd;
    typedef logic [STATUS_BITS-1:0] t_status;

    localparam t_cmd CMD_NONE = 4'd0;
    localparam t_cmd CMD_PUSH = 4'd1;
    localparam t_cmd CMD_POP  = 4'd2;
    localparam t_cmd CMD_ADD  = 4'd3;
    localparam t_cmd CMD_SUB  = 4'd4;
    localparam t_cmd CMD_MUL  = 4'd5;
    localparam t_cmd CMD_DIV  = 4'd6;
    localparam t_cmd CMD_JUMP = 4'd7;
    localparam t_cmd CMD_CMP  = 4'd8;
    localparam t_cmd CMD_JCMP = 4'd9;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_OVER    = 2'd1;
    localparam t_status ST_UNDER   = 2'd2;
    localparam t_status ST_BADJUMP = 2'd3;

    typedef struct packed {
        logic start;
        logic div;
    } t_alu_ctl;

endpackage

### rtl/smx_stack_ram.sv
// Stack word memory with one write port and one registered read port.
module smx_stack_ram #(
    parameter int DEPTH     = 256,
    parameter int WORD_BITS = 32,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WORD_BITS-1:0] i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WORD_BITS-1:0] o_rdata
);

    logic [WORD_BITS-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

### rtl/smx_alu.sv
// Multicycle multiply and signed divide unit for the stack machine.
module smx_alu #(
    parameter int WORD_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  smx_pkg::t_alu_ctl     i_ctl,
    input  logic [WORD_BITS-1:0]  i_a,
    input  logic [WORD_BITS-1:0]  i_b,
    output logic                  o_done,
    output logic [WORD_BITS-1:0]  o_result
);
    import smx_pkg::*;

    localparam int HB = (WORD_BITS + 1) / 2;
    localparam int CW = $clog2(WORD_BITS + 1);

    typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_FIX} t_state;

    t_state               r_state;
    logic [CW-1:0]        r_cnt;
    logic [WORD_BITS-1:0] r_a;
    logic [WORD_BITS-1:0] r_b;
    logic [2*HB-1:0]      r_prod;
    logic [WORD_BITS-1:0] r_acc;
    logic [WORD_BITS-1:0] r_rem;
    logic [WORD_BITS-1:0] r_quo;
    logic                 r_neg;
    logic                 r_done;
    logic [WORD_BITS-1:0] r_res;

    logic [HB-1:0]        mul_x;
    logic [HB-1:0]        mul_y;
    logic [2*HB-1:0]      mul_p;
    logic [WORD_BITS-1:0] prod_w;
    logic [WORD_BITS-1:0] prod_sh;
    logic [WORD_BITS:0]   trial;
    logic [WORD_BITS-1:0] a_abs;
    logic [WORD_BITS-1:0] b_abs;

    always_comb begin
        mul_x   = (r_cnt == CW'(1)) ? HB'(r_a >> HB) : r_a[HB-1:0];
        mul_y   = (r_cnt == CW'(2)) ? HB'(r_b >> HB) : r_b[HB-1:0];
        mul_p   = mul_x * mul_y;
        prod_w  = r_prod[WORD_BITS-1:0];
        prod_sh = prod_w << HB;
        trial   = {r_rem, r_quo[WORD_BITS-1]} - {1'b0, r_b};
        a_abs   = i_a[WORD_BITS-1] ? (~i_a + WORD_BITS'(1)) : i_a;
        b_abs   = i_b[WORD_BITS-1] ? (~i_b + WORD_BITS'(1)) : i_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                A_IDLE: begin
                    if (i_ctl.start) begin
                        r_cnt <= '0;
                        r_b   <= i_ctl.div ? b_abs : i_b;
                        r_a   <= i_a;
                        r_rem <= '0;
                        if (!i_ctl.div) begin
                            r_state <= A_MUL;
                        end else if (i_b == '0) begin
                            r_quo   <= '0;
                            r_neg   <= 1'b0;
                            r_state <= A_FIX;
                        end else begin
                            r_quo   <= a_abs;
                            r_neg   <= i_a[WORD_BITS-1] ^ i_b[WORD_BITS-1];
                            r_state <= A_DIV;
                        end
                    end
                end
                A_MUL: begin
                    r_prod <= mul_p;
                    r_cnt  <= r_cnt + CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_acc <= prod_w;
                    end else if (r_cnt == CW'(2)) begin
                        r_acc <= r_acc + prod_sh;
                    end else if (r_cnt == CW'(3)) begin
                        r_res   <= r_acc + prod_sh;
                        r_done  <= 1'b1;
                        r_state <= A_IDLE;
                    end
                end
                A_DIV: begin
                    if (!trial[WORD_BITS]) begin
                        r_rem <= trial[WORD_BITS-1:0];
                        r_quo <= {r_quo[WORD_BITS-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[WORD_BITS-2:0], r_quo[WORD_BITS-1]};
                        r_quo <= {r_quo[WORD_BITS-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(WORD_BITS - 1)) begin
                        r_state <= A_FIX;
                    end
                end
                A_FIX: begin
                    r_res   <= r_neg ? (~r_quo + WORD_BITS'(1)) : r_quo;
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

### rtl/stack_machine_execute.sv
// Top level of the stack machine execution unit: sequencer, registers and output stage.
//
//   channel   direction  handshake                 payload
//   input     in         i_valid / o_stall         i_cmd, i_operand
//   output    out        o_valid / i_stall         o_status, o_ip_value, o_stack_depth
//   config    in         i_cfg_valid / o_cfg_ready i_cfg_data (program length)
//
// None, push, pop, jump and compare pass through S_TOP and S_PUT; add, subtract and
// jump_compare also through S_NEXT, as the second operand comes from the one read port of
// the stack memory in the cycle after the first. Multiply and divide wait in S_ALU on a
// half-width multiplier, or on a restoring divider at one quotient bit per cycle.
// No request or write is taken during reset; after it the stack is empty and the pointer
// and program length are zero. A waiting output holds the next result in the final state.
`include "assert_macros.svh"

module stack_machine_execute #(
    parameter int STACK_DEPTH = 256,
    parameter int WORD_BITS   = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  smx_pkg::t_cmd                           i_cmd,
    input  logic signed [smx_pkg::OPERAND_BITS-1:0] i_operand,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output smx_pkg::t_status                        o_status,
    output logic signed [smx_pkg::IP_BITS-1:0]      o_ip_value,
    output logic [smx_pkg::DEPTH_OUT_BITS-1:0]      o_stack_depth,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [smx_pkg::PLEN_BITS-1:0]           i_cfg_data
);
    import smx_pkg::*;

    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int CNTW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {S_IDLE, S_TOP, S_NEXT, S_ALU, S_PUT} t_state;

    t_state                         r_state, n_state;
    t_cmd                           r_cmd;
    logic signed [OPERAND_BITS-1:0] r_operand;
    logic [CNTW-1:0]                r_count, n_count;
    logic signed [IP_BITS-1:0]      r_ip, n_ip;
    logic [PLEN_BITS-1:0]           r_plen;
    logic [WORD_BITS-1:0]           r_a, n_a;
    t_status                        r_status, n_status;
    logic                           r_out_valid;
    t_status                        r_out_status;
    logic signed [IP_BITS-1:0]      r_out_ip;
    logic [DEPTH_OUT_BITS-1:0]      r_out_depth;

    logic                 out_free;
    logic                 accept;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;
    t_alu_ctl             alu_ctl;
    logic                 alu_done;
    logic [WORD_BITS-1:0] alu_result;
    logic [WORD_BITS-1:0] opw;
    logic                 empty;
    logic                 full;
    logic                 bad_jump;

    assign out_free    = !r_out_valid || !i_stall;
    assign o_stall     = !i_rst_n ||
                         !((r_state == S_IDLE) || ((r_state == S_PUT) && out_free));
    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = i_rst_n;

    assign opw       = WORD_BITS'(r_operand);
    assign empty     = (r_count == '0);
    assign full      = (r_count == CNTW'(STACK_DEPTH));
    assign bad_jump  = r_operand[OPERAND_BITS-1] || (r_operand[OPERAND_BITS-2:0] > r_plen);
    assign ram_raddr = (r_state == S_TOP) ? AW'(r_count - CNTW'(2)) : AW'(r_count - CNTW'(1));

    smx_stack_ram #(
        .DEPTH     (STACK_DEPTH),
        .WORD_BITS (WORD_BITS),
        .ADDR_BITS (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    smx_alu #(
        .WORD_BITS (WORD_BITS)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (alu_ctl),
        .i_a      (r_a),
        .i_b      (ram_rdata),
        .o_done   (alu_done),
        .o_result (alu_result)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ip      = r_ip;
        n_status  = r_status;
        n_a       = r_a;
        ram_we    = 1'b0;
        ram_waddr = AW'(r_count);
        ram_wdata = opw;
        alu_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_TOP;
                end
            end
            S_TOP: begin
                n_status = ST_OK;
                n_state  = S_PUT;
                n_a      = ram_rdata;
                unique case (r_cmd)
                    CMD_PUSH: begin
                        if (full) begin
                            n_status = ST_OVER;
                        end else begin
                            ram_we  = 1'b1;
                            n_count = r_count + CNTW'(1);
                        end
                    end
                    CMD_POP: begin
                        if (empty) begin
                            n_status = ST_UNDER;
                        end else begin
                            n_count = r_count - CNTW'(1);
                        end
                    end
                    CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_JCMP: begin
                        if (empty) begin
                            n_status = ST_UNDER;
                        end else if (r_count == CNTW'(1)) begin
                            n_count  = '0;
                            n_status = ST_UNDER;
                        end else begin
                            n_state = S_NEXT;
                        end
                    end
                    CMD_JUMP: begin
                        if (bad_jump) begin
                            n_status = ST_BADJUMP;
                        end else begin
                            n_ip = r_operand;
                        end
                    end
                    CMD_CMP: begin
                        if (empty) begin
                            n_status = ST_UNDER;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(r_count - CNTW'(1));
                            ram_wdata = (ram_rdata == opw) ? WORD_BITS'(1) : '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_NEXT: begin
                n_state   = S_PUT;
                ram_waddr = AW'(r_count - CNTW'(2));
                unique case (r_cmd)
                    CMD_ADD: begin
                        ram_we    = 1'b1;
                        ram_wdata = r_a + ram_rdata;
                        n_count   = r_count - CNTW'(1);
                    end
                    CMD_SUB: begin
                        ram_we    = 1'b1;
                        ram_wdata = r_a - ram_rdata;
                        n_count   = r_count - CNTW'(1);
                    end
                    CMD_MUL, CMD_DIV: begin
                        alu_ctl.start = 1'b1;
                        alu_ctl.div   = (r_cmd == CMD_DIV);
                        n_state       = S_ALU;
                    end
                    CMD_JCMP: begin
                        n_count = r_count - CNTW'(2);
                        if (r_a == ram_rdata) begin
                            n_ip = r_operand;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_ALU: begin
                ram_waddr = AW'(r_count - CNTW'(2));
                ram_wdata = alu_result;
                if (alu_done) begin
                    ram_we  = 1'b1;
                    n_count = r_count - CNTW'(1);
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (out_free) begin
                    n_state = accept ? S_TOP : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ip        <= '0;
            r_plen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ip     <= n_ip;
            r_status <= n_status;
            r_a      <= n_a;
            if (i_cfg_valid) begin
                r_plen <= i_cfg_data;
            end
            if (accept) begin
                r_cmd     <= i_cmd;
                r_operand <= i_operand;
            end
            if ((r_state == S_PUT) && out_free) begin
                r_out_valid  <= 1'b1;
                r_out_status <= r_status;
                r_out_ip     <= r_ip;
                r_out_depth  <= DEPTH_OUT_BITS'(r_count);
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_ip_value    = r_out_ip;
    assign o_stack_depth = r_out_depth;

    `AST_NEXT(a_accept_reads_top, i_clk, i_rst_n, accept, r_state == S_TOP,
              "accept did not lead to top read")
    `AST_IMPL(a_alu_done_waited, i_clk, i_rst_n, alu_done, r_state == S_ALU,
              "alu result while not waiting")
    `AST_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNTW'(STACK_DEPTH),
              "stack count beyond depth")
    `AST_IMPL(a_write_in_exec, i_clk, i_rst_n, ram_we,
              (r_state == S_TOP) || (r_state == S_NEXT) || (r_state == S_ALU),
              "stack write outside execution")

endmodule

### bench/tb_top.sv
// Self-checking testbench for the stack machine execution unit.
`timescale 1ns / 100ps

module tb_top;
    import smx_pkg::*;

    localparam int   CLK_PERIOD      = 20;
    localparam int   STACK_SLOTS     = 256;
    localparam int   WATCHDOG_LIMIT  = 3000;
    localparam int   SETTLE_CYCLES   = 50;
    localparam t_cmd CMD_UNUSED_LOW  = 4'd10;
    localparam t_cmd CMD_UNUSED_HIGH = 4'd15;

    typedef struct {
        t_cmd        cmd;
        logic [31:0] operand;
    } t_instr;

    typedef struct {
        t_status     status;
        logic [31:0] ip;
        logic [8:0]  depth;
    } t_exec_result;

    logic                                i_clk         = 1'b0;
    logic                                i_rst_n       = 1'b0;
    logic                                i_valid       = 1'b0;
    logic                                o_stall;
    t_cmd                                i_cmd         = CMD_NONE;
    logic signed [OPERAND_BITS-1:0]      i_operand     = '0;
    logic                                o_valid;
    logic                                i_stall       = 1'b0;
    t_status                             o_status;
    logic signed [IP_BITS-1:0]           o_ip_value;
    logic [DEPTH_OUT_BITS-1:0]           o_stack_depth;
    logic                                i_cfg_valid   = 1'b0;
    logic                                o_cfg_ready;
    logic [PLEN_BITS-1:0]                i_cfg_data    = '0;

    t_instr       instr_q[$];
    t_exec_result results_due[$];

    logic [31:0]          stack_words [STACK_SLOTS];
    int                   stack_used    = 0;
    logic [31:0]          instr_ptr     = '0;
    logic [PLEN_BITS-1:0] prog_len      = '0;

    int planned_depth = 0;
    int planned_items = 0;
    int send_idle_pct = 12;
    int recv_stall_pct = 54;
    int mismatches = 0;
    int results_seen = 0;

    stack_machine_execute #(
        .STACK_DEPTH (STACK_SLOTS),
        .WORD_BITS   (32)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_operand     (i_operand),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_ip_value    (o_ip_value),
        .o_stack_depth (o_stack_depth),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic execute_instr(input t_cmd cmd, input logic [31:0] operand);
        logic [31:0]  a;
        logic [31:0]  b;
        logic [31:0]  r;
        t_status      st;
        t_exec_result res;
        st = ST_OK;
        case (cmd)
            CMD_PUSH: begin
                if (stack_used < STACK_SLOTS) begin
                    stack_words[stack_used] = operand;
                    stack_used++;
                end else begin
                    st = ST_OVER;
                end
            end
            CMD_POP: begin
                if (stack_used > 0) stack_used--;
                else st = ST_UNDER;
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_JCMP: begin
                if (stack_used < 2) begin
                    stack_used = 0;
                    st = ST_UNDER;
                end else begin
                    a = stack_words[stack_used - 1];
                    b = stack_words[stack_used - 2];
                    stack_used -= 2;
                    if (cmd == CMD_JCMP) begin
                        if (a == b) instr_ptr = operand;
                    end else begin
                        case (cmd)
                            CMD_ADD: r = a + b;
                            CMD_SUB: r = a - b;
                            CMD_MUL: r = a * b;
                            default: begin
                                if (b == 32'd0) r = 32'd0;
                                else if (b == 32'hFFFF_FFFF) r = 32'd0 - a;
                                else r = $signed(a) / $signed(b);
                            end
                        endcase
                        stack_words[stack_used] = r;
                        stack_used++;
                    end
                end
            end
            CMD_JUMP: begin
                if (operand[31] || operand[30:0] > prog_len) st = ST_BADJUMP;
                else instr_ptr = operand;
            end
            CMD_CMP: begin
                if (stack_used == 0) st = ST_UNDER;
                else stack_words[stack_used - 1] = (stack_words[stack_used - 1] == operand) ? 1 : 0;
            end
            default: begin
            end
        endcase
        res.status = st;
        res.ip     = instr_ptr;
        res.depth  = stack_used[8:0];
        results_due.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("MISMATCH result %0d %s: got %0h, expected %0h",
                 results_seen, what, got, want);
    endtask

    always @(posedge i_clk) begin : instr_driver
        t_instr next_instr;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) execute_instr(i_cmd, i_operand);
            if (!i_valid || !o_stall) begin
                if (instr_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_instr = instr_q.pop_front();
                    i_valid   <= 1'b1;
                    i_cmd     <= next_instr.cmd;
                    i_operand <= next_instr.operand;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_exec_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    report_mismatch("unexpected result, status", 32'(o_status), 32'd0);
                end else begin
                    want = results_due.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", 32'(o_status), 32'(want.status));
                    if (o_ip_value !== want.ip) report_mismatch("ip_value", o_ip_value, want.ip);
                    if (o_stack_depth !== want.depth)
                        report_mismatch("stack_depth", 32'(o_stack_depth), 32'(want.depth));
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void add_item(input t_cmd cmd, input logic [31:0] operand);
        t_instr it;
        it.cmd     = cmd;
        it.operand = operand;
        instr_q.push_back(it);
        planned_items++;
        case (cmd)
            CMD_PUSH: if (planned_depth < STACK_SLOTS) planned_depth++;
            CMD_POP:  if (planned_depth > 0) planned_depth--;
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                if (planned_depth >= 2) planned_depth--;
                else planned_depth = 0;
            end
            CMD_JCMP: begin
                if (planned_depth >= 2) planned_depth -= 2;
                else planned_depth = 0;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            5, 6:    return 32'($urandom_range(20)) - 32'd10;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_target();
        case ($urandom_range(5))
            0:       return {1'b0, prog_len};
            1:       return {1'b0, prog_len} + 32'd1;
            2:       return $urandom_range({1'b0, prog_len});
            3:       return 32'h8000_0000 | $urandom();
            default: return $urandom();
        endcase
    endfunction

    function automatic t_cmd pick_arith();
        case ($urandom_range(3))
            0:       return CMD_ADD;
            1:       return CMD_SUB;
            2:       return CMD_MUL;
            default: return CMD_DIV;
        endcase
    endfunction

    task automatic queue_random_program(input int count, input bit with_fill);
        int          start;
        int          fill_point;
        int          pick;
        bit          filled;
        logic [31:0] x;
        logic [31:0] y;
        t_cmd        op;
        start      = planned_items;
        fill_point = $urandom_range(count / 2);
        filled     = 1'b0;
        while (planned_items - start < count) begin
            if (with_fill && !filled && planned_items - start >= fill_point) begin
                filled = 1'b1;
                while (planned_depth < STACK_SLOTS) add_item(CMD_PUSH, pick_word());
                repeat ($urandom_range(1, 3)) add_item(CMD_PUSH, pick_word());
                add_item(pick_arith(), $urandom());
                add_item(CMD_CMP, pick_word());
                add_item(CMD_PUSH, pick_word());
                add_item(CMD_PUSH, pick_word());
                while (planned_depth > 0) begin
                    if ($urandom_range(3) == 0) add_item(pick_arith(), $urandom());
                    else add_item(CMD_POP, $urandom());
                end
            end else if (planned_depth > 24) begin
                repeat ($urandom_range(4, 16)) add_item(CMD_POP, $urandom());
            end else begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    add_item(t_cmd'($urandom_range(CMD_UNUSED_HIGH)), $urandom());
                end else if (pick < 32) begin
                    op = pick_arith();
                    x  = pick_word();
                    y  = pick_word();
                    if (op == CMD_DIV && $urandom_range(3) == 0) begin
                        x = 32'h8000_0000;
                        y = 32'hFFFF_FFFF;
                    end
                    add_item(CMD_PUSH, y);
                    add_item(CMD_PUSH, x);
                    add_item(op, $urandom());
                end else if (pick < 42) begin
                    x = pick_word();
                    add_item(CMD_PUSH, x);
                    add_item(CMD_CMP, $urandom_range(1) ? x : pick_word());
                end else if (pick < 52) begin
                    x = pick_word();
                    add_item(CMD_PUSH, x);
                    add_item(CMD_PUSH, $urandom_range(1) ? x : pick_word());
                    add_item(CMD_JCMP, pick_target());
                end else if (pick < 64) begin
                    add_item(CMD_JUMP, pick_target());
                end else if (pick < 76) begin
                    add_item(CMD_POP, $urandom());
                end else if (pick < 82) begin
                    add_item($urandom_range(1) ? pick_arith() : CMD_JCMP, pick_target());
                end else if (pick < 86) begin
                    add_item(CMD_CMP, pick_word());
                end else if (pick < 92) begin
                    add_item(CMD_PUSH, pick_word());
                end else if (pick < 96 && planned_depth < 12) begin
                    while (planned_depth > 0) add_item(CMD_POP, $urandom());
                    repeat ($urandom_range(1, 2)) add_item(CMD_POP, $urandom());
                end else begin
                    add_item(t_cmd'($urandom_range(CMD_UNUSED_HIGH, CMD_UNUSED_LOW)), $urandom());
                end
            end
        end
    endtask

    task automatic write_prog_len(input logic [PLEN_BITS-1:0] value);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        prog_len = value;
    endtask

    task automatic wait_drained();
        while (instr_q.size() != 0 || i_valid || results_due.size() != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_prog_len(31'd5);

        add_item(CMD_POP, 32'd0);
        add_item(CMD_ADD, 32'd0);
        add_item(CMD_PUSH, 32'h7FFF_FFFF);
        add_item(CMD_SUB, 32'd0);
        add_item(CMD_PUSH, 32'd0);
        add_item(CMD_PUSH, 32'd123);
        add_item(CMD_DIV, 32'd0);
        add_item(CMD_PUSH, 32'hFFFF_FFFF);
        add_item(CMD_PUSH, 32'h8000_0000);
        add_item(CMD_DIV, 32'd0);
        add_item(CMD_PUSH, 32'h7FFF_FFFF);
        add_item(CMD_ADD, 32'd0);
        add_item(CMD_MUL, 32'd0);
        add_item(CMD_CMP, 32'd0);
        add_item(CMD_JUMP, 32'hFFFF_FFFF);
        add_item(CMD_JUMP, 32'd5);
        add_item(CMD_JUMP, 32'd6);
        add_item(CMD_JUMP, 32'd0);
        add_item(CMD_PUSH, 32'd7);
        add_item(CMD_PUSH, 32'd7);
        add_item(CMD_JCMP, 32'hFFFF_FFF0);
        add_item(CMD_PUSH, 32'd1);
        add_item(CMD_PUSH, 32'd2);
        add_item(CMD_JCMP, 32'd3);
        add_item(CMD_NONE, 32'hFFFF_FFFF);
        add_item(CMD_UNUSED_HIGH, 32'h5A5A_A5A5);
        wait_drained();

        write_prog_len('0);
        queue_random_program(300, 1'b1);
        wait_drained();

        send_idle_pct  = 54;
        recv_stall_pct = 12;
        write_prog_len({PLEN_BITS{1'b1}});
        queue_random_program(300, 1'b1);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_prog_len(PLEN_BITS'($urandom_range(300, 2)));
        queue_random_program(60, 1'b0);
        wait_drained();
        write_prog_len(31'd1);
        queue_random_program(60, 1'b0);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
